>>> hw/rtl/mdm_pkg.sv
// Package for the modulated delay mixer: sizes, the sine ROM contents and the
// command and configuration structs shared by the controller, datapath and CSR block.
// Depends on nothing.
package mdm_pkg;

   localparam int SAMPLE_WIDTH      = 16;
   localparam int MAX_DELAY_ENTRIES = 65536;
   localparam int SINE_TABLE_BITS   = 10;

   localparam int ADDR_W       = $clog2(MAX_DELAY_ENTRIES);
   localparam int FILL_W       = ADDR_W + 1;
   localparam int LEN_W        = 17;
   localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int SINE_ENTRIES = 1 << SINE_TABLE_BITS;
   localparam int SINE_W       = 16;
   localparam int GAIN_W       = 18;
   localparam int CHAN_W       = 4;
   localparam int CNT_W        = 3;

   localparam logic [31:0] START_PHASE_RESET = 32'd0;

   typedef logic signed [SINE_W-1:0] sine_rom_type [SINE_ENTRIES];

   // Quarter-wave odd polynomial in Q28, rounded to Q1.15.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type   rom;
      longint unsigned p;
      longint unsigned q;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned y;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         p = (longint'(k) << (16 - SINE_TABLE_BITS)) & 64'hFFFF;
         q = p >> 14;
         x = p & 64'h3FFF;
         if (q[0]) begin
            x = 64'd16384 - x;
         end
         x2 = (x * x) >> 14;
         t  = 64'd1256734;
         t  = 64'd21392319 - ((t * x2) >> 14);
         t  = 64'd173399641 - ((t * x2) >> 14);
         t  = 64'd421657428 - ((t * x2) >> 14);
         y  = (t * x) >> 14;
         y  = (y + 64'd4096) >> 13;
         if (y > 64'd32767) begin
            y = 64'd32767;
         end
         rom[k] = q[1] ? -SINE_W'(y) : SINE_W'(y);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Step commands from the sequencer to the datapath.
   typedef struct packed {
      logic start;      // latch sample, read delay memory and sine ROM
      logic gain_mult;  // amplitude times sine magnitude
      logic commit;     // frame gain, phase, channel count, memory write
      logic mix_mult;   // dry and wet products
      logic out_load;   // round, saturate and load the output register
   } mdm_cmd_type;

   // Effective configuration and one-cycle control pulses from the CSR block.
   typedef struct packed {
      logic [CHAN_W-1:0] chan_eff;
      logic [FILL_W-1:0] len_eff;
      logic [31:0]       phase_step;
      logic [31:0]       start_phase;
      logic [15:0]       amplitude;
      logic [15:0]       wet_eff;
      logic              clear;
      logic              phase_load;
   } mdm_cfg_type;

endpackage

>>> hw/rtl/modulated_delay_mix.sv
// Top level of the modulated delay mixer: CSR block, sequencer and datapath.
// Depends on mdm_pkg, mdm_csr, mdm_ctrl and mdm_datapath.
//
// Usage: interleaved Q1.15 samples enter on the req_ stream, one sample per
// transaction, channel 0 of each frame first. Each accepted sample gives exactly
// one mixed, saturated sample on the rsp_ stream, in order.
// A sample is accepted only while the block is idle, so one sample is in
// work at a time; the five steps share the gain and mix multipliers and the
// single read and write of the delay memory per sample.
// The next sample is accepted while a finished result still waits on rsp_; if
// the receiver stalls longer, the block holds its next result and accepts
// nothing more until the output register frees.
// The user writes registers over the csr_ port only with no sample in flight;
// the block does not enforce it. Writing the buffer length or the amplitude
// empties the delay memory; writing the start phase loads the modulation phase.
// Reset: registers take their default values and the delay memory reads as zero
// at once, since a fill count marks the entries written since the last clear;
// no clearing pass is needed.
module modulated_delay_mix (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [mdm_pkg::TDATA_W-1:0] req_tdata,   // [15:0] sample_in
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [mdm_pkg::TDATA_W-1:0] rsp_tdata,   // [15:0] sample_out
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [4:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import mdm_pkg::*;

   mdm_cmd_type cmd;
   mdm_cfg_type cfg;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;

   assign csr_pready = 1'b1;
   assign sample_in  = req_tdata[SAMPLE_WIDTH-1:0];
   assign rsp_tdata  = TDATA_W'($unsigned(sample_out));

   mdm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   mdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mdm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .sample_in  (sample_in),
      .sample_out (sample_out)
   );

endmodule

>>> hw/rtl/mdm_csr.sv
// Configuration register file of the modulated delay mixer on an APB-style port.
// Depends on mdm_pkg for sizes and the configuration struct.
module mdm_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output mdm_pkg::mdm_cfg_type cfg
);
   import mdm_pkg::*;

   localparam logic [2:0] REG_CHANNELS    = 3'd0;
   localparam logic [2:0] REG_BUFFER_LEN  = 3'd1;
   localparam logic [2:0] REG_PHASE_STEP  = 3'd2;
   localparam logic [2:0] REG_START_PHASE = 3'd3;
   localparam logic [2:0] REG_AMPLITUDE   = 3'd4;
   localparam logic [2:0] REG_WETNESS     = 3'd5;

   logic [CHAN_W-1:0] channels_ff;
   logic [LEN_W-1:0]  buffer_length_ff;
   logic [31:0]       phase_step_ff;
   logic [31:0]       start_phase_ff;
   logic [15:0]       amplitude_ff;
   logic [15:0]       wetness_ff;

   logic       wr_en;
   logic [2:0] reg_idx;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         channels_ff      <= CHAN_W'(2);
         buffer_length_ff <= LEN_W'(65536);
         phase_step_ff    <= 32'd89478;
         start_phase_ff   <= START_PHASE_RESET;
         amplitude_ff     <= 16'd4096;
         wetness_ff       <= 16'd16384;
      end else if (wr_en) begin
         case (reg_idx)
            REG_CHANNELS:    channels_ff      <= csr_pwdata[CHAN_W-1:0];
            REG_BUFFER_LEN:  buffer_length_ff <= csr_pwdata[LEN_W-1:0];
            REG_PHASE_STEP:  phase_step_ff    <= csr_pwdata;
            REG_START_PHASE: start_phase_ff   <= csr_pwdata;
            REG_AMPLITUDE:   amplitude_ff     <= csr_pwdata[15:0];
            REG_WETNESS:     wetness_ff       <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CHANNELS:    csr_prdata = 32'(channels_ff);
         REG_BUFFER_LEN:  csr_prdata = 32'(buffer_length_ff);
         REG_PHASE_STEP:  csr_prdata = phase_step_ff;
         REG_START_PHASE: csr_prdata = start_phase_ff;
         REG_AMPLITUDE:   csr_prdata = 32'(amplitude_ff);
         REG_WETNESS:     csr_prdata = 32'(wetness_ff);
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      if (channels_ff == '0) begin
         cfg.chan_eff = CHAN_W'(1);
      end else if (channels_ff > CHAN_W'(8)) begin
         cfg.chan_eff = CHAN_W'(8);
      end else begin
         cfg.chan_eff = channels_ff;
      end

      if (buffer_length_ff == '0) begin
         cfg.len_eff = FILL_W'(1);
      end else if (32'(buffer_length_ff) > 32'(MAX_DELAY_ENTRIES)) begin
         cfg.len_eff = FILL_W'(MAX_DELAY_ENTRIES);
      end else begin
         cfg.len_eff = FILL_W'(buffer_length_ff);
      end

      cfg.wet_eff     = (wetness_ff > 16'd32768) ? 16'd32768 : wetness_ff;
      cfg.phase_step  = phase_step_ff;
      cfg.start_phase = csr_pwdata;
      cfg.amplitude   = amplitude_ff;
      // Changing the length or the depth empties the delay memory.
      cfg.clear       = wr_en && (reg_idx == REG_BUFFER_LEN || reg_idx == REG_AMPLITUDE);
      cfg.phase_load  = wr_en && (reg_idx == REG_START_PHASE);
   end

endmodule

>>> hw/rtl/mdm_ctrl.sv
// Sequencer of the modulated delay mixer: steps one sample through the datapath
// and owns both stream handshakes. Depends on mdm_pkg for the command struct.
module mdm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output mdm_pkg::mdm_cmd_type cmd
);
   import mdm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_GAIN,
      ST_MIX,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.start     = (state_ff == ST_IDLE) && req_tvalid;
      cmd.gain_mult = (state_ff == ST_READ);
      cmd.commit    = (state_ff == ST_GAIN);
      cmd.mix_mult  = (state_ff == ST_MIX);
      cmd.out_load  = (state_ff == ST_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_GAIN;
            ST_GAIN: state_ff <= ST_MIX;
            ST_MIX:  state_ff <= ST_DONE;
            ST_DONE: begin
               // Holds here while an earlier result still waits on the output.
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> hw/rtl/mdm_datapath.sv
// Datapath of the modulated delay mixer: delay memory, sine ROM, phase and
// channel state, gain and mix multipliers, rounding and saturation.
// Depends on mdm_pkg for sizes, the sine ROM and the command and config structs.
module mdm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  mdm_pkg::mdm_cmd_type              cmd,
   input  mdm_pkg::mdm_cfg_type              cfg,
   input  logic signed [mdm_pkg::SAMPLE_WIDTH-1:0] sample_in,
   output logic signed [mdm_pkg::SAMPLE_WIDTH-1:0] sample_out
);
   import mdm_pkg::*;

   localparam int AMP_W = 16 + SINE_W - 1;
   localparam int GP_W  = AMP_W + 16;
   localparam int P1_W  = SAMPLE_WIDTH + 18;
   localparam int P2_W  = SAMPLE_WIDTH + GAIN_W;
   localparam int ACC_W = P2_W + 3;
   localparam int R_W   = ACC_W - 15;
   localparam logic signed [R_W-1:0] SMAX_R = R_W'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [R_W-1:0] SMIN_R = -SMAX_R - R_W'(1);

   logic signed [SAMPLE_WIDTH-1:0] delay_mem [MAX_DELAY_ENTRIES];

   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [SAMPLE_WIDTH-1:0] mem_q_ff;
   logic                           mem_hit_ff;
   logic signed [SINE_W-1:0]       sine_ff;
   logic [AMP_W-1:0]               amp_mag_ff;
   logic signed [GAIN_W-1:0]       gain_ff;
   logic [ADDR_W-1:0]              wp_ff;
   logic [FILL_W-1:0]              fill_ff;
   logic [31:0]                    phase_ff;
   logic [CNT_W-1:0]               chan_cnt_ff;
   logic signed [P1_W-1:0]         p1_ff;
   logic signed [P2_W-1:0]         p2_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_ff;

   logic signed [SINE_W-1:0]       sine_neg;
   logic [SINE_W-2:0]              sine_mag;
   logic [GP_W-1:0]                gain_prod;
   logic signed [GAIN_W-1:0]       gain_mag;
   logic signed [GAIN_W-1:0]       gain_in;
   logic [FILL_W-1:0]              wp_next;
   logic [CHAN_W-1:0]              cnt_next;
   logic signed [17:0]             dry;
   logic signed [SAMPLE_WIDTH-1:0] delayed;
   logic signed [ACC_W-1:0]        acc;
   logic signed [ACC_W-1:0]        rnd;
   logic signed [R_W-1:0]          r;
   logic signed [SAMPLE_WIDTH-1:0] sat;

   always_comb begin
      sine_neg  = -sine_ff;
      sine_mag  = sine_ff[SINE_W-1] ? sine_neg[SINE_W-2:0] : sine_ff[SINE_W-2:0];
      gain_prod = GP_W'(amp_mag_ff) * GP_W'(cfg.wet_eff);
      gain_mag  = gain_prod[GP_W-1 -: GAIN_W];
      gain_in   = sine_ff[SINE_W-1] ? -gain_mag : gain_mag;
      wp_next   = FILL_W'(wp_ff) + FILL_W'(1);
      cnt_next  = CHAN_W'(chan_cnt_ff) + CHAN_W'(1);
      dry       = 18'sd32768 - 18'(cfg.wet_eff);
      delayed   = mem_hit_ff ? mem_q_ff : '0;
      acc       = ACC_W'(p1_ff) + (ACC_W'(p2_ff) <<< 2);
      // Add one half, then floor: round half up.
      rnd       = acc + ACC_W'(16384);
      r         = rnd[ACC_W-1:15];
      if (r > SMAX_R) begin
         sat = SMAX_R[SAMPLE_WIDTH-1:0];
      end else if (r < SMIN_R) begin
         sat = SMIN_R[SAMPLE_WIDTH-1:0];
      end else begin
         sat = r[SAMPLE_WIDTH-1:0];
      end
   end

   // Delay memory: one read when a sample arrives, one write at commit.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mem_q_ff <= delay_mem[wp_ff];
      end
      if (cmd.commit) begin
         delay_mem[wp_ff] <= x_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff       <= sample_in;
         sine_ff    <= SINE_ROM[phase_ff[31 -: SINE_TABLE_BITS]];
         // Entries at or above the fill count have not been written since clearing.
         mem_hit_ff <= (FILL_W'(wp_ff) < fill_ff);
      end
      if (cmd.gain_mult) begin
         amp_mag_ff <= AMP_W'(cfg.amplitude) * AMP_W'(sine_mag);
      end
      if (cmd.mix_mult) begin
         p1_ff <= P1_W'(x_ff) * P1_W'(dry);
         p2_ff <= P2_W'(delayed) * P2_W'(gain_ff);
      end
      if (cmd.out_load) begin
         out_ff <= sat;
      end
   end

   // Running state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         fill_ff     <= '0;
         phase_ff    <= START_PHASE_RESET;
         chan_cnt_ff <= '0;
         gain_ff     <= '0;
      end else begin
         if (cmd.commit) begin
            if (chan_cnt_ff == '0) begin
               gain_ff  <= gain_in;
               phase_ff <= phase_ff + cfg.phase_step;
            end
            chan_cnt_ff <= (cnt_next >= cfg.chan_eff) ? '0 : cnt_next[CNT_W-1:0];
            wp_ff       <= (wp_next >= cfg.len_eff) ? '0 : wp_next[ADDR_W-1:0];
            if (FILL_W'(wp_ff) == fill_ff) begin
               fill_ff <= fill_ff + FILL_W'(1);
            end
         end
         if (cfg.clear) begin
            wp_ff   <= '0;
            fill_ff <= '0;
         end
         if (cfg.phase_load) begin
            phase_ff <= cfg.start_phase;
         end
      end
   end

   assign sample_out = out_ff;

endmodule

>>> hw/rtl/mdm_checker.sv
// Port-level checks for the modulated delay mixer, bound to the top level.
// Depends on mdm_pkg for the stream width.
module mdm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [mdm_pkg::TDATA_W-1:0] rsp_tdata,
   input logic                        csr_pready
);
   import mdm_pkg::*;

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   // One sample at a time: no acceptance right after an acceptance.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second sample accepted while one is in flight");

   // A new result appears only at the end of a sample's work.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a sample in flight");

   // After reset the block is empty and ready.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("configuration port not ready");

endmodule

bind modulated_delay_mix mdm_checker u_mdm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

>>> bench/mdm_tb_pkg.sv
// Register indexes of the modulated delay mixer as the bench sees them.
// Shared by the checker and the stimulus top. Depends on nothing.
package mdm_tb_pkg;

   // Register i lies at byte address 4*i on the csr_ port.
   typedef enum logic [2:0] {
      REG_CHANNELS,
      REG_BUFFER_LENGTH,
      REG_PHASE_STEP,
      REG_START_PHASE,
      REG_AMPLITUDE,
      REG_WETNESS,
      REG_SPARE
   } csr_index_type;

endpackage

>>> bench/mdm_mix_checker.sv
// Checker for the modulated delay mixer: follows register writes and accepted samples,
// predicts every mixed sample and compares it with the rsp_ stream.
// Depends on mdm_pkg and mdm_tb_pkg.
module mdm_mix_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [mdm_pkg::TDATA_W-1:0] req_tdata,   // [15:0] sample_in
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [mdm_pkg::TDATA_W-1:0] rsp_tdata,   // [15:0] sample_out
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [4:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   input  logic                        csr_pready,
   output int unsigned                 outstanding,
   output int unsigned                 error_count
);
   import mdm_tb_pkg::*;

   localparam int SW = mdm_pkg::SAMPLE_WIDTH;
   localparam int TB = mdm_pkg::SINE_TABLE_BITS;

   logic [3:0]  cfg_channels;
   logic [16:0] cfg_length;
   logic [31:0] cfg_step;
   logic [15:0] cfg_amp;
   logic [15:0] cfg_wet;

   // Entries never written since the last clear read as zero.
   logic [SW-1:0] echo_mem [int unsigned];
   int unsigned   wr_ptr;
   logic [31:0]   mod_phase;
   int unsigned   chan_pos;
   longint        frame_gain;
   logic [SW-1:0] mix_q [$];
   int unsigned   fail_tally;

   function automatic int unsigned chan_limit();
      if (cfg_channels == 0) return 1;
      if (cfg_channels > 8) return 8;
      return cfg_channels;
   endfunction

   function automatic int unsigned length_limit();
      if (cfg_length == 0) return 1;
      if (cfg_length > mdm_pkg::MAX_DELAY_ENTRIES) return mdm_pkg::MAX_DELAY_ENTRIES;
      return cfg_length;
   endfunction

   // Quarter-wave odd polynomial in Q28, rounded to Q1.15, mirrored into four quadrants.
   function automatic longint sine_at(input logic [TB-1:0] k);
      longint unsigned ph16;
      longint unsigned pos;
      longint unsigned sq;
      longint unsigned poly;
      longint unsigned mag;
      ph16 = (longint'(k) << (16 - TB)) & 64'hFFFF;
      pos  = ph16 & 64'h3FFF;
      if (ph16[14]) pos = 64'd16384 - pos;
      sq   = (pos * pos) >> 14;
      poly = 64'd1256734;
      poly = 64'd21392319 - ((poly * sq) >> 14);
      poly = 64'd173399641 - ((poly * sq) >> 14);
      poly = 64'd421657428 - ((poly * sq) >> 14);
      mag  = (((poly * pos) >> 14) + 64'd4096) >> 13;
      if (mag > 64'd32767) mag = 64'd32767;
      return ph16[15] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic [SW-1:0] predict_mix(input logic [SW-1:0] raw);
      longint          x;
      longint          delayed;
      longint          acc;
      longint          r;
      longint          s;
      longint          mag;
      longint          wet;
      longint          smax;
      longint unsigned g;
      int unsigned     len;
      int unsigned     wp;
      x    = longint'(signed'(raw));
      wet  = (cfg_wet > 16'd32768) ? 32768 : cfg_wet;
      len  = length_limit();
      wp   = wr_ptr % len;
      // The gain is refreshed at the first channel of each frame only.
      if (chan_pos == 0) begin
         s          = sine_at(mod_phase[31 -: TB]);
         mag        = (s < 0) ? -s : s;
         g          = (cfg_amp * mag * wet) >> 29;
         frame_gain = (s < 0) ? -$signed(g) : $signed(g);
         mod_phase  = mod_phase + cfg_step;
      end
      chan_pos++;
      if (chan_pos >= chan_limit()) chan_pos = 0;
      delayed     = echo_mem.exists(wp) ? longint'(signed'(echo_mem[wp])) : 0;
      echo_mem[wp] = raw;
      wr_ptr      = (wp + 1 >= len) ? 0 : wp + 1;
      acc  = x * (32768 - wet) + delayed * frame_gain * 4;
      r    = (acc + 16384) >>> 15;
      smax = (longint'(1) << (SW - 1)) - 1;
      if (r > smax) r = smax;
      if (r < -smax - 1) r = -smax - 1;
      return r[SW-1:0];
   endfunction

   always @(posedge clock) begin
      logic [SW-1:0] want;
      if (reset) begin
         cfg_channels = 4'd2;
         cfg_length   = 17'd65536;
         cfg_step     = 32'd89478;
         cfg_amp      = 16'd4096;
         cfg_wet      = 16'd16384;
         echo_mem.delete();
         mix_q.delete();
         wr_ptr       = 0;
         mod_phase    = mdm_pkg::START_PHASE_RESET;
         chan_pos     = 0;
         frame_gain   = 0;
         fail_tally   = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[4:2]))
               REG_CHANNELS: begin
                  cfg_channels = csr_pwdata[3:0];
               end
               REG_BUFFER_LENGTH: begin
                  cfg_length = csr_pwdata[16:0];
                  echo_mem.delete();
                  wr_ptr = 0;
               end
               REG_PHASE_STEP: begin
                  cfg_step = csr_pwdata;
               end
               REG_START_PHASE: begin
                  mod_phase = csr_pwdata;
               end
               REG_AMPLITUDE: begin
                  cfg_amp = csr_pwdata[15:0];
                  echo_mem.delete();
                  wr_ptr = 0;
               end
               REG_WETNESS: begin
                  cfg_wet = csr_pwdata[15:0];
               end
               default: begin
               end
            endcase
         end
         // Results are matched before new samples are queued, so an early result
         // can never pair with the sample accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (mix_q.size() == 0) begin
               $error("sample_out: expected none, actual %0d", $signed(rsp_tdata[SW-1:0]));
               fail_tally++;
            end else begin
               want = mix_q.pop_front();
               if (rsp_tdata[SW-1:0] !== want) begin
                  $error("sample_out: expected %0d, actual %0d",
                         $signed(want), $signed(rsp_tdata[SW-1:0]));
                  fail_tally++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            mix_q.push_back(predict_mix(req_tdata[SW-1:0]));
         end
      end
      outstanding <= mix_q.size();
      error_count <= fail_tally;
   end

endmodule

>>> bench/modulated_delay_mix_tb.sv
// Stimulus top for the modulated delay mixer: clock, reset, register writes and
// sample traffic under changing back-pressure, plus the final verdict.
// Depends on mdm_pkg, mdm_tb_pkg, modulated_delay_mix and mdm_mix_checker.
module modulated_delay_mix_tb;
   import mdm_tb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [mdm_pkg::TDATA_W-1:0] req_tdata;   // [15:0] sample_in
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [mdm_pkg::TDATA_W-1:0] rsp_tdata;   // [15:0] sample_out
   logic                        csr_psel;
   logic                        csr_penable;
   logic                        csr_pwrite;
   logic [4:0]                  csr_paddr;
   logic [31:0]                 csr_pwdata;
   logic [31:0]                 csr_prdata;
   logic                        csr_pready;

   int unsigned outstanding;
   int unsigned error_count;
   int unsigned send_idle;
   int unsigned recv_idle;
   int unsigned cur_chan;
   int unsigned cycle_count;

   modulated_delay_mix i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mdm_mix_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .outstanding (outstanding),
      .error_count (error_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic send_sample(input logic [15:0] value);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // Registers may only change once every sample in flight has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         1: return 16'($urandom_range(64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_settings();
      int unsigned ch;
      int unsigned len;
      logic [31:0] value;
      if ($urandom_range(1) == 1) begin
         ch = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
         cur_chan = (ch == 0) ? 1 : ((ch > 8) ? 8 : ch);
         value = {($urandom_range(3) == 0) ? 28'($urandom) : 28'd0, 4'(ch)};
         write_reg(REG_CHANNELS, value);
      end
      if ($urandom_range(2) != 0) begin
         case ($urandom_range(5))
            0: len = $urandom_range(131071);
            1: begin
               case ($urandom_range(3))
                  0: len = 0;
                  1: len = 1;
                  2: len = 65536;
                  default: len = 131071;
               endcase
            end
            2: len = $urandom_range(1, 40);
            default: len = cur_chan * $urandom_range(1, 6);
         endcase
         value = {($urandom_range(3) == 0) ? 15'($urandom) : 15'd0, 17'(len)};
         write_reg(REG_BUFFER_LENGTH, value);
      end
      if ($urandom_range(1) == 1) begin
         case ($urandom_range(4))
            0: value = 32'd0;
            1: value = 32'hFFFF_FFFF;
            2: value = $urandom_range(32'h00FF_FFFF);
            default: value = $urandom;
         endcase
         write_reg(REG_PHASE_STEP, value);
      end
      if ($urandom_range(1) == 1) begin
         value = ($urandom_range(4) == 0) ? {2'($urandom_range(3)), 30'd0} : $urandom;
         write_reg(REG_START_PHASE, value);
      end
      if ($urandom_range(1) == 1) begin
         case ($urandom_range(4))
            0: value = 32'd0;
            1: value = 32'd65535;
            default: value = $urandom_range(65535);
         endcase
         if ($urandom_range(3) == 0) value[31:16] = 16'($urandom);
         write_reg(REG_AMPLITUDE, value);
      end
      if ($urandom_range(1) == 1) begin
         case ($urandom_range(5))
            0: value = 32'd0;
            1: value = 32'd32768;
            2: value = $urandom_range(65535, 32769);
            default: value = $urandom_range(32768);
         endcase
         if ($urandom_range(3) == 0) value[31:16] = 16'($urandom);
         write_reg(REG_WETNESS, value);
      end
   endtask

   task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle);
      send_idle = s_idle;
      recv_idle = r_idle;
      for (int seg = 0; seg < 5; seg++) begin
         wait_drained();
         random_settings();
         repeat ($urandom_range(70, 30)) send_sample(pick_sample());
      end
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("modulated_delay_mix_tb: done, errors");
      $finish;
   end

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      send_idle   = 31;
      recv_idle   = 74;
      cur_chan    = 2;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings with an empty delay memory: only the dry path counts.
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
      send_sample(16'hFFFF);

      // Single-entry delay at full depth, full wet and peak sine drives saturation.
      wait_drained();
      write_reg(REG_CHANNELS, 32'd1);
      write_reg(REG_BUFFER_LENGTH, 32'd1);
      write_reg(REG_PHASE_STEP, 32'd0);
      write_reg(REG_START_PHASE, 32'h4000_0000);
      write_reg(REG_AMPLITUDE, 32'd65535);
      write_reg(REG_WETNESS, 32'd32768);
      send_sample(16'h7FFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h8000);

      // Shrinking the channel count in the middle of a frame.
      wait_drained();
      write_reg(REG_CHANNELS, 32'd8);
      write_reg(REG_BUFFER_LENGTH, 32'd16);
      write_reg(REG_PHASE_STEP, 32'h1000_0000);
      repeat (5) send_sample(pick_sample());
      wait_drained();
      write_reg(REG_CHANNELS, 32'd3);
      send_sample(16'h1234);
      send_sample(16'hEDCB);

      // Zero channels and zero length act as one; negative sine, dry-only mix.
      wait_drained();
      write_reg(REG_CHANNELS, 32'd0);
      write_reg(REG_BUFFER_LENGTH, 32'd0);
      write_reg(REG_START_PHASE, 32'hC000_0000);
      write_reg(REG_WETNESS, 32'd0);
      send_sample(16'h4000);
      send_sample(16'h7FFF);

      // Oversized channels, length and wetness saturate; the spare index is ignored.
      wait_drained();
      write_reg(REG_CHANNELS, 32'd15);
      write_reg(REG_BUFFER_LENGTH, 32'h0001_FFFF);
      write_reg(REG_WETNESS, 32'd65535);
      write_reg(REG_AMPLITUDE, 32'd0);
      write_reg(REG_SPARE, 32'hFFFF_FFFF);
      send_sample(16'h8000);
      send_sample(16'h7FFF);

      // A length that is not a multiple of the channel count mixes across channels.
      wait_drained();
      write_reg(REG_CHANNELS, 32'd2);
      write_reg(REG_BUFFER_LENGTH, 32'd3);
      write_reg(REG_AMPLITUDE, 32'd4096);
      write_reg(REG_WETNESS, 32'd16384);
      cur_chan = 2;
      repeat (4) send_sample(pick_sample());

      run_phase(31, 74);
      run_phase(74, 31);
      run_phase(0, 0);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("modulated_delay_mix_tb: done, clean");
      end else begin
         $display("modulated_delay_mix_tb: done, errors");
      end
      $finish;
   end

endmodule
